FILE: hw/rtl/dtwcs_pkg.sv
// Shared types and constants for the DTW column-stream cost engine.
// No dependencies; dtwcs_front, dtwcs_back and the top level import this package.
package dtwcs_pkg;

    localparam int CFG_ROWS_BITS  = 11;
    localparam int CFG_BAND_BITS  = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COL_BITS       = 16;
    localparam int ROW_OUT_BITS   = 10;
    localparam int COST_IN_BITS   = 16;
    localparam int ACC_OUT_BITS   = 32;
    localparam int CELL_COST_BITS = 32;
    localparam int CELL_ROW_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_ENABLE = 2'd2;

    localparam logic [CFG_ROWS_BITS-1:0] ROW_COUNT_RESET   = 11'd1024;
    localparam logic [CFG_BAND_BITS-1:0] BAND_WIDTH_RESET  = 10'd1023;
    localparam logic                     BAND_ENABLE_RESET = 1'b0;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;
    localparam logic [1:0] DIR_UP   = 2'd3;

    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    typedef struct packed {
        logic [COST_IN_BITS-1:0] local_cost;
        logic                    new_matrix;
    } in_item_t;

    typedef struct packed {
        logic [ACC_OUT_BITS-1:0] accumulated_cost;
        logic [1:0]              direction;
        logic                    in_band;
        logic [ROW_OUT_BITS-1:0] row_index;
        logic [COL_BITS-1:0]     column_index;
        logic                    column_end;
    } out_item_t;

    typedef struct packed {
        logic                      valid;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_ROWS_BITS-1:0]  data;
    } cfg_wr_t;

    // Classified cell passed from the front end to the back end.
    typedef struct packed {
        logic [CELL_COST_BITS-1:0] cost;
        logic [CELL_ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]       col;
        logic                      band_ok;
        logic                      last;
    } cell_t;

endpackage

FILE: hw/rtl/dtwcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtwcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/dtwcs_fifo.sv
// Small register queue with full/empty flags; DEPTH is a power of two.
// No dependencies.
module dtwcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/dtwcs_front.sv
// Front end: configuration registers, row/column counters and band check.
// Depends on dtwcs_pkg; feeds classified cells into the cell queue.
module dtwcs_front #(
    parameter int ROWS_MAX  = 1024,
    parameter int COST_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  dtwcs_pkg::in_item_t item,
    input  dtwcs_pkg::cfg_wr_t  cfg_wr,
    output logic               q_push,
    input  logic               q_full,
    output dtwcs_pkg::cell_t    q_data
);

    import dtwcs_pkg::*;

    localparam int RB = $clog2(ROWS_MAX);
    localparam int CW = (RB + 1 > CFG_ROWS_BITS) ? RB + 1 : CFG_ROWS_BITS;
    localparam int DW = (RB > COL_BITS) ? RB : COL_BITS;

    logic [CFG_ROWS_BITS-1:0] row_count_reg;
    logic [CFG_BAND_BITS-1:0] band_width_reg;
    logic                     band_enable_reg;
    logic [RB-1:0]            row_reg, row_next;
    logic [COL_BITS-1:0]      col_reg, col_next;

    logic [CW-1:0]       rows_cfg, rows;
    logic [RB-1:0]       r;
    logic [COL_BITS-1:0] c;
    logic [DW-1:0]       r_ext, c_ext, row_col_gap;
    logic                band_ok, last, accept;

    always_comb
    begin
        rows_cfg = CW'(row_count_reg);
        if (rows_cfg == '0)
        begin
            rows = CW'(1);
        end
        else if (rows_cfg > CW'(ROWS_MAX))
        begin
            rows = CW'(ROWS_MAX);
        end
        else
        begin
            rows = rows_cfg;
        end

        r = item.new_matrix ? '0 : row_reg;
        c = item.new_matrix ? '0 : col_reg;

        r_ext       = DW'(r);
        c_ext       = DW'(c);
        row_col_gap = (r_ext > c_ext) ? r_ext - c_ext : c_ext - r_ext;
        band_ok     = !band_enable_reg || (row_col_gap <= DW'(band_width_reg));
        last        = (CW'(r) + CW'(1)) >= rows;

        accept = push && !q_full;

        if (last)
        begin
            row_next = '0;
            col_next = (c == COL_MAX) ? c : c + COL_BITS'(1);
        end
        else
        begin
            row_next = r + RB'(1);
            col_next = c;
        end

        q_data.cost    = CELL_COST_BITS'(COST_BITS'(item.local_cost));
        q_data.row     = CELL_ROW_BITS'(r);
        q_data.col     = c;
        q_data.band_ok = band_ok;
        q_data.last    = last;
    end

    assign q_push = accept;
    assign full   = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= ROW_COUNT_RESET;
            band_width_reg  <= BAND_WIDTH_RESET;
            band_enable_reg <= BAND_ENABLE_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_ROW_COUNT:   row_count_reg   <= cfg_wr.data;
                CFG_BAND_WIDTH:  band_width_reg  <= cfg_wr.data[CFG_BAND_BITS-1:0];
                CFG_BAND_ENABLE: band_enable_reg <= cfg_wr.data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: hw/rtl/dtwcs_back.sv
// Back end: reads the previous column, picks the best neighbor, adds the cost.
// Depends on dtwcs_pkg; drives the column store and the result queue.
module dtwcs_back #(
    parameter int ROWS_MAX  = 1024,
    parameter int COST_BITS = 16,
    parameter int SUM_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  dtwcs_pkg::cell_t              q_cell,
    output logic                          q_pop,
    output logic                          ram_rd_en,
    output logic [$clog2(ROWS_MAX)-1:0]   ram_rd_addr,
    input  logic [((SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS)-1:0] ram_rd_data,
    output logic                          ram_wr_en,
    output logic [$clog2(ROWS_MAX)-1:0]   ram_wr_addr,
    output logic [((SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS)-1:0] ram_wr_data,
    input  logic                          o_full,
    output logic                          o_push,
    output dtwcs_pkg::out_item_t          o_data
);

    import dtwcs_pkg::*;

    localparam int RB = $clog2(ROWS_MAX);
    localparam int VW = (SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS;
    localparam logic [VW-1:0] INF = VW'({SUM_BITS{1'b1}});
    localparam logic [VW-1:0] LIM = INF - VW'(1);

    logic          b_valid_reg, b_valid_next;
    cell_t         b_cell_reg;
    logic          fwd_reg;
    logic [VW-1:0] fwd_data_reg;
    logic [VW-1:0] above_reg;
    logic [VW-1:0] diag_reg;

    logic                 b_fire, hit;
    logic [RB-1:0]        b_row;
    logic [COST_BITS-1:0] cost;
    logic                 r0, c0;
    logic [VW-1:0]        left_mem, up, left, diag, best, acc;
    logic [VW:0]          sum;
    logic [1:0]           dir;

    assign b_row  = RB'(b_cell_reg.row);
    assign b_fire = b_valid_reg && !o_full;
    assign q_pop  = !q_empty && (!b_valid_reg || b_fire);

    assign ram_rd_en   = q_pop;
    assign ram_rd_addr = RB'(q_cell.row);
    assign ram_wr_en   = b_fire;
    assign ram_wr_addr = b_row;
    assign ram_wr_data = acc;

    // forward a write to the row being read in the same cycle
    assign hit = q_pop && b_fire && (RB'(q_cell.row) == b_row);

    assign b_valid_next = q_pop || (b_valid_reg && !b_fire);

    always_comb
    begin
        cost     = COST_BITS'(b_cell_reg.cost);
        r0       = (b_row == '0);
        c0       = (b_cell_reg.col == '0);
        left_mem = fwd_reg ? fwd_data_reg : ram_rd_data;
        up       = r0 ? INF : above_reg;
        left     = c0 ? INF : left_mem;
        diag     = (r0 || c0) ? INF : diag_reg;

        best = diag;
        dir  = DIR_DIAG;
        if (up < best)
        begin
            best = up;
            dir  = DIR_UP;
        end
        if (left < best)
        begin
            best = left;
            dir  = DIR_LEFT;
        end

        sum = {1'b0, best} + (VW + 1)'(cost);

        if (r0 && c0)
        begin
            acc = b_cell_reg.band_ok ? VW'(cost) : INF;
            dir = DIR_NONE;
        end
        else if (!b_cell_reg.band_ok || (best == INF))
        begin
            acc = INF;
            dir = DIR_NONE;
        end
        else if (sum >= (VW + 1)'(LIM))
        begin
            acc = LIM;
        end
        else
        begin
            acc = sum[VW-1:0];
        end

        o_data.accumulated_cost = ACC_OUT_BITS'(acc);
        o_data.direction        = dir;
        o_data.in_band          = b_cell_reg.band_ok;
        o_data.row_index        = ROW_OUT_BITS'(b_row);
        o_data.column_index     = b_cell_reg.col;
        o_data.column_end       = b_cell_reg.last;
    end

    assign o_push = b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            above_reg   <= INF;
            diag_reg    <= INF;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            if (q_pop)
            begin
                fwd_reg <= hit;
            end
            if (b_fire)
            begin
                above_reg <= acc;
                diag_reg  <= left;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_cell_reg <= q_cell;
        end
        if (b_fire)
        begin
            fwd_data_reg <= acc;
        end
    end

endmodule

FILE: hw/rtl/dtw_cost_matrix_column_stream.sv
// Top level of the DTW accumulated-cost engine with optional band limit.
// Depends on dtwcs_pkg, dtwcs_front, dtwcs_fifo, dtwcs_back and dtwcs_ram.
//
// Usage:
//   Cells enter in column-major order on item (local_cost, new_matrix); a
//   cell is taken when push is high and full is low. new_matrix marks cell
//   (0,0) of a new matrix. Results leave as a queue: while empty is low the
//   oldest result sits on result and is taken when pop is high.
//   Registers row_count, band_width and band_enable are written through the
//   cfg_valid/cfg_ready channel (cfg_ready is always high); the user must
//   write them only while idle, as the block itself does not enforce it.
//   An accepted cell passes the cell queue, the back end's cell register
//   and the result queue. Throughput: one cell per cycle while pop keeps up.
//   Reset: counters restart at cell (0,0), registers take their reset
//   values, both queues empty. The column store needs no clearing.
//   When pop is held low the result queue fills, the back end holds its
//   cell, the cell queue fills and full rises; nothing is dropped.
module dtw_cost_matrix_column_stream #(
    parameter int ROWS_MAX  = 1024,
    parameter int COST_BITS = 16,
    parameter int SUM_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  dtwcs_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output dtwcs_pkg::out_item_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [dtwcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dtwcs_pkg::CFG_ROWS_BITS-1:0]  cfg_data
);

    import dtwcs_pkg::*;

    localparam int RB = $clog2(ROWS_MAX);
    localparam int VW = (SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS;
    localparam int CELL_W = $bits(cell_t);
    localparam int OUT_W = $bits(out_item_t);

    cfg_wr_t            cfg_wr;
    logic               mid_push, mid_full, mid_pop, mid_empty;
    cell_t              mid_wr_cell, mid_rd_cell;
    logic [CELL_W-1:0]  mid_rd_data;
    logic               ram_rd_en, ram_wr_en;
    logic [RB-1:0]      ram_rd_addr, ram_wr_addr;
    logic [VW-1:0]      ram_rd_data, ram_wr_data;
    logic               out_push, out_full;
    out_item_t          out_wr_item;
    logic [OUT_W-1:0]   out_rd_data;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    dtwcs_front #(
        .ROWS_MAX  (ROWS_MAX),
        .COST_BITS (COST_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .cfg_wr (cfg_wr),
        .q_push (mid_push),
        .q_full (mid_full),
        .q_data (mid_wr_cell)
    );

    dtwcs_fifo #(
        .WIDTH (CELL_W),
        .DEPTH (2)
    ) u_cell_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr_cell),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign mid_rd_cell = cell_t'(mid_rd_data);

    dtwcs_back #(
        .ROWS_MAX  (ROWS_MAX),
        .COST_BITS (COST_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (mid_empty),
        .q_cell      (mid_rd_cell),
        .q_pop       (mid_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .o_full      (out_full),
        .o_push      (out_push),
        .o_data      (out_wr_item)
    );

    dtwcs_ram #(
        .WIDTH (VW),
        .DEPTH (ROWS_MAX)
    ) u_column_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dtwcs_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_wr_item),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign result = out_item_t'(out_rd_data);

endmodule
